@@ rtl/rgb_3x3_convolution_filter_defines.svh @@
// Assertion macros for the 3x3 convolution filter.
`ifndef RGB_3X3_CONVOLUTION_FILTER_DEFINES_SVH
`define RGB_3X3_CONVOLUTION_FILTER_DEFINES_SVH
`ifndef SYNTH
`define RGB3_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rgb3 assertion failed");
`define RGB3_ASSERT_NEXT(lbl, clk, rst, pre, post) \
   lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) \
      else $error("rgb3 assertion failed");
`else
`define RGB3_ASSERT(lbl, clk, rst, prop)
`define RGB3_ASSERT_NEXT(lbl, clk, rst, pre, post)
`endif
`endif

@@ rtl/rgb3_pkg.sv @@
package rgb3_pkg;

   localparam int MAX_WIDTH_DEF  = 2048;
   localparam int MAX_HEIGHT_DEF = 2048;

   localparam int PIX_W   = 8;
   localparam int PIXEL_W = 3 * PIX_W;
   localparam int POS_W   = 11;
   localparam int REG_W   = 32;
   localparam int ADDR_W  = 4;
   localparam int MODE_W  = 3;
   localparam int DIM_W   = 12;
   localparam int MAG_W   = 17;
   localparam int ROOT_W  = 9;
   localparam int MIN_DIM = 3;

   localparam logic [MODE_W-1:0] MODE_BOX       = 3'd0;
   localparam logic [MODE_W-1:0] MODE_GAUSS     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_SOBEL_X   = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SOBEL_Y   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_MAGNITUDE = 3'd4;

   localparam logic [1:0] REG_MODE   = 2'd0;
   localparam logic [1:0] REG_WIDTH  = 2'd1;
   localparam logic [1:0] REG_HEIGHT = 2'd2;

   localparam logic [DIM_W-1:0] WIDTH_RESET  = 12'd640;
   localparam logic [DIM_W-1:0] HEIGHT_RESET = 12'd480;

   // 2^16 / 9 rounded up; exact floor for sums below 2^12
   localparam logic [12:0] DIV9_RECIP = 13'd7282;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_READ,
      ST_SQRT,
      ST_EMIT
   } state_type;

   typedef logic [PIXEL_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type older;
      pixel_type newer;
   } line_word_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [DIM_W-1:0]  width;
      logic [DIM_W-1:0]  height;
   } cfg_type;

   typedef struct packed {
      logic [PIX_W-1:0] in_blue;
      logic [PIX_W-1:0] in_green;
      logic [PIX_W-1:0] in_red;
   } req_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_blue;
      logic [PIX_W-1:0] out_green;
      logic [PIX_W-1:0] out_red;
      logic [POS_W-1:0] out_row;
      logic [POS_W-1:0] out_col;
      logic             frame_done;
   } rsp_payload_type;

   typedef struct packed {
      logic [PIX_W-1:0] box;
      logic [PIX_W-1:0] gauss;
      logic [PIX_W-1:0] sobel_x;
      logic [PIX_W-1:0] sobel_y;
   } kernel_type;

   function automatic logic [PIX_W-1:0] clamp8(input logic signed [10:0] v);
      logic [PIX_W-1:0] r;
      if (v[10]) begin
         r = '0;
      end else if (v[9:8] != 2'b00) begin
         r = '1;
      end else begin
         r = v[7:0];
      end
      return r;
   endfunction

   // taps[row*3 + col], row 0 is the oldest line, col 0 the leftmost
   function automatic kernel_type kernel_eval(input logic [8:0][PIX_W-1:0] taps);
      logic [11:0]        box_sum;
      logic [11:0]        gauss_sum;
      logic [24:0]        box_prod;
      logic [9:0]         x_pos;
      logic [9:0]         x_neg;
      logic [9:0]         y_pos;
      logic [9:0]         y_neg;
      logic signed [10:0] gx;
      logic signed [10:0] gy;
      kernel_type         k;
      box_sum = 12'(taps[0]) + 12'(taps[1]) + 12'(taps[2])
              + 12'(taps[3]) + 12'(taps[4]) + 12'(taps[5])
              + 12'(taps[6]) + 12'(taps[7]) + 12'(taps[8]);
      gauss_sum = 12'(taps[0]) + 12'({taps[1], 1'b0}) + 12'(taps[2])
                + 12'({taps[3], 1'b0}) + 12'({taps[4], 2'b00}) + 12'({taps[5], 1'b0})
                + 12'(taps[6]) + 12'({taps[7], 1'b0}) + 12'(taps[8]);
      x_pos = 10'(taps[2]) + 10'({taps[5], 1'b0}) + 10'(taps[8]);
      x_neg = 10'(taps[0]) + 10'({taps[3], 1'b0}) + 10'(taps[6]);
      y_pos = 10'(taps[6]) + 10'({taps[7], 1'b0}) + 10'(taps[8]);
      y_neg = 10'(taps[0]) + 10'({taps[1], 1'b0}) + 10'(taps[2]);
      gx = $signed({1'b0, x_pos}) - $signed({1'b0, x_neg});
      gy = $signed({1'b0, y_pos}) - $signed({1'b0, y_neg});
      box_prod = 25'(box_sum) * 25'(DIV9_RECIP);
      k.box     = box_prod[23:16];
      k.gauss   = gauss_sum[11:4];
      k.sobel_x = clamp8(gx);
      k.sobel_y = clamp8(gy);
      return k;
   endfunction

endpackage

@@ rtl/rgb3_if.sv @@
interface rgb3_req_if;
   logic                       valid;
   logic                       ready;
   rgb3_pkg::req_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface rgb3_rsp_if;
   logic                       valid;
   logic                       ready;
   rgb3_pkg::rsp_payload_type  payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ rtl/rgb3_csr.sv @@
module rgb3_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rgb3_pkg::ADDR_W-1:0]   paddr,
   input  logic [rgb3_pkg::REG_W-1:0]    pwdata,
   output logic [rgb3_pkg::REG_W-1:0]    prdata,
   output logic                          pready,
   output rgb3_pkg::cfg_type             cfg
);

   logic [rgb3_pkg::MODE_W-1:0] mode_ff;
   logic [rgb3_pkg::DIM_W-1:0]  width_ff;
   logic [rgb3_pkg::DIM_W-1:0]  height_ff;
   logic [1:0]                  reg_index;
   logic                        wr_en;

   assign reg_index = paddr[rgb3_pkg::ADDR_W-1:2];
   assign pready    = 1'b1;
   assign wr_en     = psel && penable && pwrite && pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= rgb3_pkg::MODE_BOX;
         width_ff  <= rgb3_pkg::WIDTH_RESET;
         height_ff <= rgb3_pkg::HEIGHT_RESET;
      end else if (wr_en) begin
         case (reg_index)
            rgb3_pkg::REG_MODE: begin
               mode_ff <= pwdata[rgb3_pkg::MODE_W-1:0];
            end
            rgb3_pkg::REG_WIDTH: begin
               width_ff <= pwdata[rgb3_pkg::DIM_W-1:0];
            end
            rgb3_pkg::REG_HEIGHT: begin
               height_ff <= pwdata[rgb3_pkg::DIM_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         rgb3_pkg::REG_MODE:   prdata = rgb3_pkg::REG_W'(mode_ff);
         rgb3_pkg::REG_WIDTH:  prdata = rgb3_pkg::REG_W'(width_ff);
         rgb3_pkg::REG_HEIGHT: prdata = rgb3_pkg::REG_W'(height_ff);
         default:              prdata = '0;
      endcase
   end

   assign cfg.mode   = mode_ff;
   assign cfg.width  = width_ff;
   assign cfg.height = height_ff;

endmodule

@@ rtl/rgb3_linebuf.sv @@
module rgb3_linebuf #(
   parameter int DEPTH = rgb3_pkg::MAX_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [$clog2(DEPTH)-1:0]      rd_addr,
   output rgb3_pkg::line_word_type       rd_data,
   input  logic                          wr_en,
   input  logic [$clog2(DEPTH)-1:0]      wr_addr,
   input  rgb3_pkg::line_word_type       wr_data
);

   // both previous lines share one word per column
   rgb3_pkg::line_word_type line_mem [DEPTH];
   rgb3_pkg::line_word_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rgb3_isqrt.sv @@
module rgb3_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [rgb3_pkg::MAG_W-1:0]    value,
   output logic                          done,
   output logic [rgb3_pkg::PIX_W-1:0]    root
);

   localparam int RW    = rgb3_pkg::ROOT_W;
   localparam int CNT_W = $clog2(RW + 1);

   logic                        run_ff;
   logic                        done_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic [RW-1:0]               r_ff;
   logic [rgb3_pkg::MAG_W-1:0]  value_ff;
   logic [rgb3_pkg::PIX_W-1:0]  root_ff;
   logic [RW-1:0]               trial;
   logic [RW-1:0]               mul_op;
   logic [2*RW-1:0]             sq;
   logic [2*RW:0]               r_sq_plus_r;
   logic [RW-1:0]               r_rnd;

   // one multiplier: trial square while bits remain, r*r for rounding at the end
   assign trial       = r_ff | (RW'(1) << (cnt_ff - CNT_W'(1)));
   assign mul_op      = (cnt_ff == '0) ? r_ff : trial;
   assign sq          = mul_op * mul_op;
   assign r_sq_plus_r = (2*RW+1)'(sq) + (2*RW+1)'(r_ff);
   assign r_rnd       = r_ff + RW'((2*RW+1)'(value_ff) > r_sq_plus_r);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == '0) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         cnt_ff   <= CNT_W'(RW);
         r_ff     <= '0;
         value_ff <= value;
      end else if (run_ff) begin
         if (cnt_ff != '0) begin
            if (sq <= (2*RW)'(value_ff)) begin
               r_ff <= trial;
            end
            cnt_ff <= cnt_ff - CNT_W'(1);
         end else begin
            root_ff <= (r_rnd[RW-1:rgb3_pkg::PIX_W] != '0) ? '1 : r_rnd[rgb3_pkg::PIX_W-1:0];
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

@@ rtl/rgb_3x3_convolution_filter.sv @@
// 3x3 RGB convolution filter.
// req: one RGB pixel per request, raster order, top row first. rsp: one
// filtered pixel with its row and column for every interior position;
// frame_done marks the last interior pixel of the frame. Border pixels
// produce no response. Configuration goes through the APB port: mode at
// 0x0, frame width at 0x4, frame height at 0x8; write it only while idle.
// Sequence: a request passes the accept step and the line-buffer read and
// kernel step; one that produces a response adds the output load, which
// registers the response and makes it valid. Magnitude mode adds the
// bit-serial square root between the kernel step and the output load.
// The single-port read of the line-buffer memory sets the per-request
// sequence; one request is in work at a time.
// Reset clears the pixel position to the frame origin and restores the
// registers (box mode, 640 x 480); line contents are don't-care until
// rows are written. A stalled rsp holds the output register; the block
// finishes the next request and waits in its output step until the
// held response is taken.
`include "rgb_3x3_convolution_filter_defines.svh"

module rgb_3x3_convolution_filter #(
   parameter int MAX_WIDTH  = rgb3_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = rgb3_pkg::MAX_HEIGHT_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   rgb3_req_if.sink                      req,
   rgb3_rsp_if.source                    rsp,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [rgb3_pkg::ADDR_W-1:0]   paddr,
   input  logic [rgb3_pkg::REG_W-1:0]    pwdata,
   output logic [rgb3_pkg::REG_W-1:0]    prdata,
   output logic                          pready
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int COLX_W = COL_W + 1;
   localparam int ROWX_W = ROW_W + 1;
   localparam int PW     = rgb3_pkg::PIX_W;

   rgb3_pkg::cfg_type          cfg;
   rgb3_pkg::state_type        state_ff;
   rgb3_pkg::state_type        state_in;
   rgb3_pkg::line_word_type    rd_data;
   rgb3_pkg::line_word_type    wr_data;
   rgb3_pkg::pixel_type        cur_ff;
   rgb3_pkg::pixel_type        win_ff [6];
   rgb3_pkg::pixel_type        column [3];
   rgb3_pkg::rsp_payload_type  pend_ff;
   rgb3_pkg::rsp_payload_type  out_ff;

   logic                       rsp_valid_ff;
   logic [COL_W-1:0]           col_ff;
   logic [COL_W-1:0]           col_in;
   logic [ROW_W-1:0]           row_ff;
   logic [ROW_W-1:0]           row_in;
   logic [COLX_W-1:0]          width_eff;
   logic [ROWX_W-1:0]          height_eff;
   logic [COLX_W-1:0]          col_next;
   logic [ROWX_W-1:0]          row_next;

   logic                       req_ready;
   logic                       req_fire;
   logic                       emit;
   logic                       frame_last;
   logic                       is_mag;
   logic                       mem_wr;
   logic                       sqrt_start;
   logic                       load_out;
   logic [2:0]                 sqrt_done;
   logic [2:0][PW-1:0]         chan_res;
   logic [2:0][PW-1:0]         roots;
   logic [2:0][rgb3_pkg::MAG_W-1:0] mag_sq;

   rgb3_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rgb3_linebuf #(
      .DEPTH (MAX_WIDTH)
   ) u_linebuf (
      .clock   (clock),
      .rd_en   (req_fire),
      .rd_addr (col_ff),
      .rd_data (rd_data),
      .wr_en   (mem_wr),
      .wr_addr (col_ff),
      .wr_data (wr_data)
   );

   // clamp geometry to 3..MAX
   always_comb begin
      if (32'(cfg.width) < rgb3_pkg::MIN_DIM) begin
         width_eff = COLX_W'(rgb3_pkg::MIN_DIM);
      end else if (32'(cfg.width) > MAX_WIDTH) begin
         width_eff = COLX_W'(MAX_WIDTH);
      end else begin
         width_eff = COLX_W'(cfg.width);
      end
      if (32'(cfg.height) < rgb3_pkg::MIN_DIM) begin
         height_eff = ROWX_W'(rgb3_pkg::MIN_DIM);
      end else if (32'(cfg.height) > MAX_HEIGHT) begin
         height_eff = ROWX_W'(MAX_HEIGHT);
      end else begin
         height_eff = ROWX_W'(cfg.height);
      end
   end

   assign req_fire   = req.valid && req_ready;
   assign req.ready  = req_ready;
   assign is_mag     = cfg.mode == rgb3_pkg::MODE_MAGNITUDE;
   assign emit       = (row_ff >= ROW_W'(2)) && (col_ff >= COL_W'(2));
   assign frame_last = ({1'b0, row_ff} == height_eff - ROWX_W'(1))
                    && ({1'b0, col_ff} == width_eff - COLX_W'(1));

   assign column[0] = rd_data.older;
   assign column[1] = rd_data.newer;
   assign column[2] = cur_ff;

   assign wr_data.older = rd_data.newer;
   assign wr_data.newer = cur_ff;

   for (genvar ch = 0; ch < 3; ch++) begin : g_chan
      logic [8:0][PW-1:0]    taps;
      rgb3_pkg::kernel_type  kres;
      logic [2*PW-1:0]       sx2;
      logic [2*PW-1:0]       sy2;

      always_comb begin
         for (int r = 0; r < 3; r++) begin
            taps[r*3]   = win_ff[r][ch*PW +: PW];
            taps[r*3+1] = win_ff[r+3][ch*PW +: PW];
            taps[r*3+2] = column[r][ch*PW +: PW];
         end
         kres = rgb3_pkg::kernel_eval(taps);
      end

      assign sx2         = kres.sobel_x * kres.sobel_x;
      assign sy2         = kres.sobel_y * kres.sobel_y;
      assign mag_sq[ch]  = rgb3_pkg::MAG_W'(sx2) + rgb3_pkg::MAG_W'(sy2);

      always_comb begin
         case (cfg.mode)
            rgb3_pkg::MODE_BOX:     chan_res[ch] = kres.box;
            rgb3_pkg::MODE_GAUSS:   chan_res[ch] = kres.gauss;
            rgb3_pkg::MODE_SOBEL_X: chan_res[ch] = kres.sobel_x;
            rgb3_pkg::MODE_SOBEL_Y: chan_res[ch] = kres.sobel_y;
            default:                chan_res[ch] = kres.box;
         endcase
      end

      rgb3_isqrt u_isqrt (
         .clock (clock),
         .reset (reset),
         .start (sqrt_start),
         .value (mag_sq[ch]),
         .done  (sqrt_done[ch]),
         .root  (roots[ch])
      );
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         rgb3_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = rgb3_pkg::ST_READ;
            end
         end
         rgb3_pkg::ST_READ: begin
            if (!emit) begin
               state_in = rgb3_pkg::ST_IDLE;
            end else if (is_mag) begin
               state_in = rgb3_pkg::ST_SQRT;
            end else begin
               state_in = rgb3_pkg::ST_EMIT;
            end
         end
         rgb3_pkg::ST_SQRT: begin
            if (sqrt_done[0]) begin
               state_in = rgb3_pkg::ST_EMIT;
            end
         end
         rgb3_pkg::ST_EMIT: begin
            if (load_out) begin
               state_in = rgb3_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rgb3_pkg::ST_IDLE;
         end
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready  = 1'b0;
      mem_wr     = 1'b0;
      sqrt_start = 1'b0;
      load_out   = 1'b0;
      case (state_ff)
         rgb3_pkg::ST_IDLE: begin
            req_ready = 1'b1;
         end
         rgb3_pkg::ST_READ: begin
            mem_wr     = 1'b1;
            sqrt_start = emit && is_mag;
         end
         rgb3_pkg::ST_EMIT: begin
            load_out = !rsp_valid_ff || rsp.ready;
         end
         default: begin
         end
      endcase
   end

   // advance position; a column counter beyond a shrunk limit wraps after this pixel, a row counter after this row
   always_comb begin
      col_next = {1'b0, col_ff} + COLX_W'(1);
      row_next = {1'b0, row_ff} + ROWX_W'(1);
      col_in   = col_ff;
      row_in   = row_ff;
      if (mem_wr) begin
         if (col_next >= width_eff) begin
            col_in = '0;
            row_in = (row_next >= height_eff) ? '0 : row_next[ROW_W-1:0];
         end else begin
            col_in = col_next[COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rgb3_pkg::ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         if (load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cur_ff <= {req.payload.in_red, req.payload.in_green, req.payload.in_blue};
      end
      if (mem_wr) begin
         // shift the window one column left
         win_ff[0] <= win_ff[3];
         win_ff[1] <= win_ff[4];
         win_ff[2] <= win_ff[5];
         win_ff[3] <= column[0];
         win_ff[4] <= column[1];
         win_ff[5] <= column[2];
         pend_ff.out_blue   <= chan_res[0];
         pend_ff.out_green  <= chan_res[1];
         pend_ff.out_red    <= chan_res[2];
         pend_ff.out_row    <= rgb3_pkg::POS_W'(row_ff - ROW_W'(1));
         pend_ff.out_col    <= rgb3_pkg::POS_W'(col_ff - COL_W'(1));
         pend_ff.frame_done <= frame_last;
      end else if (sqrt_done[0]) begin
         pend_ff.out_blue  <= roots[0];
         pend_ff.out_green <= roots[1];
         pend_ff.out_red   <= roots[2];
      end
      if (load_out) begin
         out_ff <= pend_ff;
      end
   end

   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = out_ff;

   `RGB3_ASSERT_NEXT(a_accept_reads, clock, reset, req_fire, state_ff == rgb3_pkg::ST_READ)
   `RGB3_ASSERT(a_sqrt_done_state, clock, reset, sqrt_done[0] |-> state_ff == rgb3_pkg::ST_SQRT)
   `RGB3_ASSERT(a_sqrt_lockstep, clock, reset, $countones(sqrt_done) == 0 || $countones(sqrt_done) == 3)
   `RGB3_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == rgb3_pkg::ST_EMIT)

endmodule

@@ tb/sv/tb_rgb_3x3_convolution_filter.sv @@
module tb_rgb_3x3_convolution_filter;
   import rgb3_pkg::*;

   localparam int SETTLE       = 24;
   localparam int CYCLE_LIMIT  = 1_500_000;
   localparam int RANDOM_ITEMS = 1750;
   localparam int PRINT_CAP    = 40;

   logic              clock;
   logic              reset;
   logic              psel;
   logic              penable;
   logic              pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [REG_W-1:0]  pwdata;
   logic [REG_W-1:0]  prdata;
   logic              pready;

   rgb3_req_if req_ch ();
   rgb3_rsp_if rsp_ch ();

   rgb_3x3_convolution_filter uut (
      .clock   (clock),
      .reset   (reset),
      .req     (req_ch),
      .rsp     (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // shadow of the filter: registers, line stores, window and raster position
   logic [MODE_W-1:0] cur_mode;
   logic [DIM_W-1:0]  cur_width;
   logic [DIM_W-1:0]  cur_height;
   logic [23:0]       row_minus2 [MAX_WIDTH_DEF];
   logic [23:0]       row_minus1 [MAX_WIDTH_DEF];
   logic [23:0]       win_cols [6];
   int                pos_col;
   int                pos_row;

   req_payload_type   pixel_queue [$];
   rsp_payload_type   filtered_due [$];

   bit                sender_idles;
   bit                receiver_idles;
   bit                hold_sender;
   int                send_gap;
   int                rsp_wait;
   int                mismatches;
   int                cycles;
   int                pattern_idx;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int eff_dim(input logic [DIM_W-1:0] v, input int cap);
      if (v < MIN_DIM) return MIN_DIM;
      if (v > cap) return cap;
      return v;
   endfunction

   function automatic int rounded_root(input int v);
      int r;
      r = 0;
      for (int b = 256; b != 0; b = b >> 1) begin
         if ((r | b) * (r | b) <= v) r = r | b;
      end
      if (v > r * r + r) r++;
      return (r > 255) ? 255 : r;
   endfunction

   // taps[row*3 + col], row 0 the oldest line, col 0 the leftmost
   function automatic logic [7:0] convolve(input logic [8:0][7:0] taps,
                                          input logic [MODE_W-1:0] mode);
      int p [9];
      int gx, gy, cx, cy, s;
      for (int i = 0; i < 9; i++) p[i] = taps[i];
      gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
      gy = (p[6] + 2 * p[7] + p[8]) - (p[0] + 2 * p[1] + p[2]);
      cx = (gx < 0) ? 0 : (gx > 255) ? 255 : gx;
      cy = (gy < 0) ? 0 : (gy > 255) ? 255 : gy;
      case (mode)
         MODE_GAUSS:     s = (p[0] + 2 * p[1] + p[2] + 2 * p[3] + 4 * p[4] + 2 * p[5]
                              + p[6] + 2 * p[7] + p[8]) / 16;
         MODE_SOBEL_X:   s = cx;
         MODE_SOBEL_Y:   s = cy;
         MODE_MAGNITUDE: s = rounded_root(cx * cx + cy * cy);
         default:        s = (p[0] + p[1] + p[2] + p[3] + p[4] + p[5] + p[6] + p[7]
                              + p[8]) / 9;
      endcase
      return s[7:0];
   endfunction

   task automatic filter_pixel(input req_payload_type px);
      int              w, h, idx;
      logic [23:0]     fresh;
      logic [23:0]     stack [3];
      logic [8:0][7:0] taps;
      logic [7:0]      res [3];
      rsp_payload_type due;
      w = eff_dim(cur_width, MAX_WIDTH_DEF);
      h = eff_dim(cur_height, MAX_HEIGHT_DEF);
      idx = pos_col % MAX_WIDTH_DEF;
      fresh = {px.in_red, px.in_green, px.in_blue};
      stack[0] = row_minus2[idx];
      stack[1] = row_minus1[idx];
      stack[2] = fresh;
      if (pos_row >= 2 && pos_col >= 2) begin
         for (int ch = 0; ch < 3; ch++) begin
            for (int r = 0; r < 3; r++) begin
               taps[r * 3]     = win_cols[r][ch * 8 +: 8];
               taps[r * 3 + 1] = win_cols[3 + r][ch * 8 +: 8];
               taps[r * 3 + 2] = stack[r][ch * 8 +: 8];
            end
            res[ch] = convolve(taps, cur_mode);
         end
         due.out_blue   = res[0];
         due.out_green  = res[1];
         due.out_red    = res[2];
         due.out_row    = POS_W'(pos_row - 1);
         due.out_col    = POS_W'(pos_col - 1);
         due.frame_done = (pos_row == h - 1) && (pos_col == w - 1);
         filtered_due.push_back(due);
      end
      row_minus2[idx] = stack[1];
      row_minus1[idx] = fresh;
      for (int r = 0; r < 3; r++) begin
         win_cols[r]     = win_cols[3 + r];
         win_cols[3 + r] = stack[r];
      end
      // a column counter at or past a shrunken limit wraps after this pixel, a row counter after this row
      if (pos_col + 1 >= w) begin
         pos_col = 0;
         pos_row = (pos_row + 1 >= h) ? 0 : pos_row + 1;
      end else begin
         pos_col++;
      end
   endtask

   function automatic int pixels_to_origin();
      int c, r, w, h, n;
      c = pos_col;
      r = pos_row;
      w = eff_dim(cur_width, MAX_WIDTH_DEF);
      h = eff_dim(cur_height, MAX_HEIGHT_DEF);
      n = 0;
      do begin
         if (c + 1 >= w) begin
            c = 0;
            r = (r + 1 >= h) ? 0 : r + 1;
         end else begin
            c++;
         end
         n++;
      end while (c != 0 || r != 0);
      return n;
   endfunction

   task automatic report_mismatch(input string msg);
      if (mismatches < PRINT_CAP) $display("ERROR: %s", msg);
      mismatches++;
   endtask

   task automatic compare_field(input string name, input int got, input int want,
                                input rsp_payload_type at);
      if (got != want) begin
         report_mismatch($sformatf("%s at row %0d col %0d: got %0d, expected %0d",
                                   name, at.out_row, at.out_col, got, want));
      end
   endtask

   task automatic check_result(input rsp_payload_type got);
      rsp_payload_type want;
      if (filtered_due.size() == 0) begin
         report_mismatch($sformatf("unexpected result for row %0d col %0d",
                                   got.out_row, got.out_col));
      end else begin
         want = filtered_due.pop_front();
         compare_field("out_blue", got.out_blue, want.out_blue, want);
         compare_field("out_green", got.out_green, want.out_green, want);
         compare_field("out_red", got.out_red, want.out_red, want);
         compare_field("out_row", got.out_row, want.out_row, want);
         compare_field("out_col", got.out_col, want.out_col, want);
         compare_field("frame_done", got.frame_done, want.frame_done, want);
      end
   endtask

   // write a register, then read it back
   task automatic csr_set(input logic [1:0] which, input logic [REG_W-1:0] value);
      logic [REG_W-1:0] kept;
      kept = (which == REG_MODE) ? (value & REG_W'(3'h7)) : (value & REG_W'(12'hFFF));
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      case (which)
         REG_MODE:  cur_mode = kept[MODE_W-1:0];
         REG_WIDTH: cur_width = kept[DIM_W-1:0];
         default:   cur_height = kept[DIM_W-1:0];
      endcase
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata !== kept) begin
         report_mismatch($sformatf("register %0d reads %0h, expected %0h",
                                   which, prdata, kept));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic queue_pattern(input int n);
      req_payload_type px;
      int r, c;
      repeat (n) begin
         r = pattern_idx / 3;
         c = pattern_idx % 3;
         px.in_blue  = (c == 2) ? 8'hFF : 8'h00;
         px.in_green = (r % 3 == 0 || c == 0) ? 8'hFF : 8'h00;
         px.in_red   = ((r + c) % 2 == 1) ? 8'hFF : 8'h00;
         pixel_queue.push_back(px);
         pattern_idx++;
      end
   endtask

   task automatic queue_random(input int n);
      req_payload_type px;
      logic [2:0]      pick;
      repeat (n) begin
         px = req_payload_type'($urandom());
         if ($urandom_range(0, 3) == 0) begin
            // saturated channels drive the sobel clamps
            pick = 3'($urandom());
            px = {{8{pick[2]}}, {8{pick[1]}}, {8{pick[0]}}};
         end
         pixel_queue.push_back(px);
      end
   endtask

   task automatic drain(input bit pause);
      int half;
      half = pixel_queue.size() / 2;
      if (pause) begin
         do @(negedge clock); while (pixel_queue.size() > half);
         hold_sender = 1'b1;
         do @(negedge clock); while (req_ch.valid || filtered_due.size() != 0);
         hold_sender = 1'b0;
      end
      do @(negedge clock);
      while (pixel_queue.size() != 0 || req_ch.valid || filtered_due.size() != 0);
      // results never come for border pixels; let the last one finish
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic int pick_dim(input bit any_size);
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return $urandom_range(0, 2);
      if (sel == 1) return any_size ? $urandom_range(0, 4095) : $urandom_range(11, 24);
      return $urandom_range(3, 8);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         send_gap = 0;
      end else if (!req_ch.valid || req_ch.ready) begin
         if (req_ch.valid) filter_pixel(req_ch.payload);
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (pixel_queue.size() != 0 && !hold_sender) begin
            req_ch.payload <= pixel_queue.pop_front();
            req_ch.valid   <= 1'b1;
            send_gap = sender_idles ? $urandom_range(0, 11) : 0;
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_result(rsp_ch.payload);
            rsp_wait = receiver_idles ? $urandom_range(0, 11) : 0;
         end else if (rsp_wait > 0) begin
            rsp_wait--;
         end
         rsp_ch.ready <= (rsp_wait == 0);
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      int  random_sent;
      int  count;
      bit  pause;
      bit  paused_once;
      bit  partial;
      reset          = 1'b1;
      psel           = 1'b0;
      penable        = 1'b0;
      pwrite         = 1'b0;
      paddr          = '0;
      pwdata         = '0;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready   = 1'b0;
      cur_mode       = MODE_BOX;
      cur_width      = WIDTH_RESET;
      cur_height     = HEIGHT_RESET;
      pos_col        = 0;
      pos_row        = 0;
      for (int i = 0; i < 6; i++) win_cols[i] = '0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      hold_sender    = 1'b0;
      mismatches     = 0;
      cycles         = 0;
      pattern_idx    = 0;
      random_sent    = 0;
      paused_once    = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // narrow frame: a width below the minimum acts as 3, an oversized height
      // as the maximum; two priming rows, then one row per mode
      csr_set(REG_WIDTH, REG_W'(2));
      csr_set(REG_HEIGHT, '1);
      csr_set(REG_MODE, REG_W'(MODE_BOX));
      queue_pattern(6);
      drain(1'b0);
      for (int m = MODE_BOX; m <= MODE_MAGNITUDE + 1; m++) begin
         csr_set(REG_MODE, REG_W'(m));
         queue_pattern(3);
         drain(1'b0);
      end

      // shrink the height mid-frame: the row counter wraps after this row
      csr_set(REG_HEIGHT, REG_W'(3));
      queue_random(pixels_to_origin());
      drain(1'b0);

      // one full frame at the widest line, back to back
      csr_set(REG_MODE, $urandom());
      csr_set(REG_WIDTH, REG_W'(12'hFFF));
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      queue_random(pixels_to_origin());
      drain(1'b0);

      while (random_sent < RANDOM_ITEMS) begin
         partial = ($urandom_range(0, 3) == 0);
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         csr_set(REG_MODE, $urandom());
         csr_set(REG_WIDTH, {($urandom_range(0, 1) ? 20'($urandom()) : 20'h0),
                             12'(pick_dim(partial))});
         csr_set(REG_HEIGHT, {($urandom_range(0, 1) ? 20'($urandom()) : 20'h0),
                              12'(pick_dim(partial))});
         if (partial) begin
            count = $urandom_range(1, 40);
         end else begin
            count = pixels_to_origin();
            if ($urandom_range(0, 1) == 1) begin
               count += eff_dim(cur_width, MAX_WIDTH_DEF) * eff_dim(cur_height, MAX_HEIGHT_DEF);
            end
         end
         queue_random(count);
         random_sent += count;
         pause = !paused_once || ($urandom_range(0, 7) == 0);
         paused_once = 1'b1;
         drain(pause);
      end

      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rgb3_pkg.sv
rtl/rgb3_if.sv
rtl/rgb3_csr.sv
rtl/rgb3_linebuf.sv
rtl/rgb3_isqrt.sv
rtl/rgb_3x3_convolution_filter.sv
tb/sv/tb_rgb_3x3_convolution_filter.sv
